@@ hdl/grid_prefix_balance_counter_assert.svh @@
// ---------------------------------------------------------------------------
// Grid prefix balance counter assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ---------------------------------------------------------------------------
`ifndef GRID_PREFIX_BALANCE_COUNTER_ASSERT_SVH
`define GRID_PREFIX_BALANCE_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPBC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gpbc_pkg.sv @@
// ---------------------------------------------------------------------------
// Grid prefix balance counter package
// Field types, character codes and configuration register indexes.
// ---------------------------------------------------------------------------
package gpbc_pkg;

  localparam int CharW   = 8;
  localparam int CntW    = 21;
  localparam int CfgW    = 11;
  localparam int CfgIdxW = 1;

  typedef logic [CharW-1:0]   char_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [CfgW-1:0]    cfg_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam char_t CharX = 8'd88;
  localparam char_t CharY = 8'd89;

  localparam cfg_idx_t RegGridColumns = 1'b0;
  localparam cfg_idx_t RegGridRows    = 1'b1;

  localparam cfg_t CfgResetVal = 11'd1;

endpackage

@@ hdl/gpbc_in_if.sv @@
// ---------------------------------------------------------------------------
// Grid prefix balance counter cell channel
// Valid/ready channel carrying one grid cell character per beat.
// ---------------------------------------------------------------------------
interface gpbc_in_if;
  import gpbc_pkg::*;

  logic  valid;
  logic  ready;
  char_t cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink   (input valid, input cell_char, output ready);

endinterface

@@ hdl/gpbc_out_if.sv @@
// ---------------------------------------------------------------------------
// Grid prefix balance counter result channel
// Valid/ready channel carrying one balance result per beat.
// ---------------------------------------------------------------------------
interface gpbc_out_if;
  import gpbc_pkg::*;

  logic valid;
  logic ready;
  logic cell_balanced;
  cnt_t balanced_total;
  logic grid_done;

  modport source (output valid, output cell_balanced, output balanced_total,
                  output grid_done, input ready);
  modport sink   (input valid, input cell_balanced, input balanced_total,
                  input grid_done, output ready);

endinterface

@@ hdl/grid_prefix_balance_counter.sv @@
// ---------------------------------------------------------------------------
// Grid prefix balance counter
// Two-dimensional prefix counts of X and Y cells over a raster cell stream.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake          Content
//  cell_i    in   valid/ready        cell_char
//  result_o  out  valid/ready        cell_balanced, balanced_total, grid_done
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (no read-back)
//
// One cell per cycle sustained unless the result side stalls; each cell goes
// through the read stage and the result register. The line store is read on
// accept, written on leaving the read stage; a same-column read is forwarded.
// Reset clears the position, row sums and total; the line store needs none.
// A stall on the result side fills the read stage and then drops cell_i.ready.
// ---------------------------------------------------------------------------
module grid_prefix_balance_counter #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  gpbc_in_if.sink            cell_i,
  gpbc_out_if.source         result_o,
  input  logic               cfg_we_i,
  input  gpbc_pkg::cfg_idx_t cfg_idx_i,
  input  gpbc_pkg::cfg_t     cfg_data_i
);
  import gpbc_pkg::*;

  localparam int ColW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SumW  = ColW + 1;
  localparam int DimA  = (CfgW > ColW + 1) ? CfgW : ColW + 1;
  localparam int DimW  = (DimA > RowW + 1) ? DimA : RowW + 1;
  localparam int EntW  = 2 * CntW;

  typedef logic [ColW-1:0] col_t;
  typedef logic [RowW-1:0] row_t;
  typedef logic [SumW-1:0] sum_t;
  typedef logic [DimW-1:0] dim_t;

  localparam dim_t MaxColsDim = dim_t'(MAX_COLUMNS);
  localparam dim_t MaxRowsDim = dim_t'(MAX_ROWS);
  localparam dim_t OneDim     = dim_t'(1);

  // Cell waiting for its line-store read data.
  typedef struct packed {
    col_t col;
    sum_t rx;
    sum_t ry;
    logic first_row;
    logic done;
  } rd_stage_t;

  // Configuration registers.
  cfg_t cols_cfg_q, rows_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CfgResetVal;
      rows_cfg_q <= CfgResetVal;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGridColumns: cols_cfg_q <= cfg_data_i;
        RegGridRows:    rows_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one and values above the maximum act as the maximum.
  dim_t cols_eff, rows_eff, cols_ext, rows_ext;

  always_comb begin
    cols_ext = dim_t'(cols_cfg_q);
    rows_ext = dim_t'(rows_cfg_q);
    if (cols_ext == '0) begin
      cols_eff = OneDim;
    end else if (cols_ext > MaxColsDim) begin
      cols_eff = MaxColsDim;
    end else begin
      cols_eff = cols_ext;
    end
    if (rows_ext == '0) begin
      rows_eff = OneDim;
    end else if (rows_ext > MaxRowsDim) begin
      rows_eff = MaxRowsDim;
    end else begin
      rows_eff = rows_ext;
    end
  end

  // Position and current-row sums.
  col_t col_q, col_d;
  row_t row_q, row_d;
  sum_t rx_q, rx_d, ry_q, ry_d;
  sum_t rx_new, ry_new;
  logic last_col, last_row;

  rd_stage_t s1_q, s1_d;
  logic      s1_valid_q;
  logic      s1_adv;
  logic      in_acc;

  logic out_valid_q;
  logic out_bal_q;
  cnt_t out_total_q;
  logic out_done_q;
  cnt_t total_q, total_d;

  assign s1_adv       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign cell_i.ready = !s1_valid_q || s1_adv;
  assign in_acc       = cell_i.valid && cell_i.ready;

  always_comb begin
    rx_new = rx_q + sum_t'(cell_i.cell_char == CharX);
    ry_new = ry_q + sum_t'(cell_i.cell_char == CharY);
    last_col = (dim_t'(col_q) + OneDim) >= cols_eff;
    last_row = (dim_t'(row_q) + OneDim) >= rows_eff;

    s1_d.col       = col_q;
    s1_d.rx        = rx_new;
    s1_d.ry        = ry_new;
    s1_d.first_row = (row_q == '0);
    s1_d.done      = last_col && last_row;

    col_d = col_q;
    row_d = row_q;
    rx_d  = rx_q;
    ry_d  = ry_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        rx_d  = '0;
        ry_d  = '0;
        row_d = last_row ? '0 : row_q + row_t'(1);
      end else begin
        col_d = col_q + col_t'(1);
        rx_d  = rx_new;
        ry_d  = ry_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Line store of the previous row's prefix counts: Y in the upper half.
  logic [EntW-1:0] line_mem [MAX_COLUMNS];
  logic [EntW-1:0] rd_data_q;
  logic [EntW-1:0] wr_data;
  logic [EntW-1:0] fwd_data_q;
  logic            fwd_q;
  cnt_t            up_x, up_y, px, py;
  logic            balanced;
  cnt_t            total_new;

  always_comb begin
    if (s1_q.first_row) begin
      up_x = '0;
      up_y = '0;
    end else if (fwd_q) begin
      up_x = fwd_data_q[CntW-1:0];
      up_y = fwd_data_q[EntW-1:CntW];
    end else begin
      up_x = rd_data_q[CntW-1:0];
      up_y = rd_data_q[EntW-1:CntW];
    end
    px        = up_x + cnt_t'(s1_q.rx);
    py        = up_y + cnt_t'(s1_q.ry);
    wr_data   = {py, px};
    balanced  = (px == py) && (px != '0);
    total_new = total_q + cnt_t'(balanced);
    total_d   = s1_q.done ? '0 : total_new;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_q.col] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= line_mem[col_q];
    end
  end

  // A read of the entry written at the same edge sees the old data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_adv && (s1_q.col == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_bal_q   <= balanced;
      out_total_q <= total_new;
      out_done_q  <= s1_q.done;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.cell_balanced  = out_bal_q;
  assign result_o.balanced_total = out_total_q;
  assign result_o.grid_done      = out_done_q;

`include "grid_prefix_balance_counter_assert.svh"

  `GPBC_ASSERT_SAME(a_row_sums_bounded, 1'b1, (rx_q + ry_q) <= sum_t'(col_q), "row sums too big")
  `GPBC_ASSERT_SAME(a_balanced_counted, out_valid_q && out_bal_q, out_total_q != '0, "zero total")
  `GPBC_ASSERT_NEXT(a_total_cleared, s1_adv && s1_q.done, total_q == '0, "total not cleared")
  `GPBC_ASSERT_NEXT(a_same_col_fwd, in_acc && s1_adv && (s1_q.col == col_q), fwd_q, "no forward")

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Grid prefix balance counter testbench
// Streams raster grids of X, Y and neutral cells through the cell channel
// and checks every result beat against a prefix-count predictor. Both
// channels stall at random. Grid size registers are reprogrammed between
// phases, some of them in the middle of a grid.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpbc_pkg::*;

  localparam int MaxColumns    = 1024;
  localparam int MaxRows       = 1024;
  localparam int RandomItems   = 950;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic balanced;
    cnt_t total;
    logic done;
  } balance_t;

  typedef enum logic {DrillCell, DrillReg} drill_kind_e;

  typedef struct packed {
    drill_kind_e kind;
    cfg_idx_t    idx;
    cfg_t        value;
    char_t       ch;
    logic        typed;
    balance_t    want;
  } drill_row_t;

  // A 1x1 grid finishes on every cell and can never be balanced.
  localparam balance_t LoneCell = '{balanced: 1'b0, total: '0, done: 1'b1};
  localparam balance_t NoCheck  = '0;

  localparam int NumDrill = 29;
  localparam drill_row_t DrillPlan [NumDrill] = '{
    '{DrillCell, RegGridColumns, 11'd0,    8'h00,  1'b1, LoneCell},
    '{DrillCell, RegGridColumns, 11'd0,    8'hFF,  1'b1, LoneCell},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b1, LoneCell},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b1, LoneCell},
    '{DrillCell, RegGridColumns, 11'd0,    8'd87,  1'b1, LoneCell},
    '{DrillCell, RegGridColumns, 11'd0,    8'd90,  1'b1, LoneCell},
    '{DrillReg,  RegGridColumns, 11'd2,    8'h00,  1'b0, NoCheck},
    '{DrillReg,  RegGridRows,    11'd2,    8'h00,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b0, NoCheck},
    '{DrillReg,  RegGridColumns, 11'd0,    8'h00,  1'b0, NoCheck},
    '{DrillReg,  RegGridRows,    11'd2047, 8'h00,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    8'h55,  1'b0, NoCheck},
    '{DrillReg,  RegGridRows,    11'd0,    8'h00,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck},
    '{DrillReg,  RegGridColumns, 11'd2047, 8'h00,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b0, NoCheck},
    '{DrillReg,  RegGridColumns, 11'd3,    8'h00,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck},
    '{DrillReg,  RegGridRows,    11'd1024, 8'h00,  1'b0, NoCheck},
    '{DrillReg,  RegGridColumns, 11'd1024, 8'h00,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharX,  1'b0, NoCheck},
    '{DrillCell, RegGridColumns, 11'd0,    CharY,  1'b0, NoCheck}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  cfg_t     cfg_data;

  // Side band that travels with the cell beat: a typed expectation, if any.
  logic     cell_typed;
  balance_t cell_want;
  logic     steady;

  gpbc_in_if  cell_if ();
  gpbc_out_if result_if ();

  grid_prefix_balance_counter #(
    .MAX_COLUMNS (MaxColumns),
    .MAX_ROWS    (MaxRows)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: line store of the row above, row sums, position, total.
  logic [41:0] line_store [MaxColumns];
  int unsigned stored_cols = 0;
  cnt_t        row_x = '0;
  cnt_t        row_y = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  cnt_t        grid_total = '0;
  cfg_t        col_reg = CfgResetVal;
  cfg_t        row_reg = CfgResetVal;

  balance_t awaited_balances [$];

  int mismatches   = 0;
  int cells_sent   = 0;
  int results_seen = 0;
  int grids_seen   = 0;
  int balanced_seen = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;

  function automatic int unsigned dim_limit(input cfg_t value, input int unsigned limit);
    if (value == '0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic balance_t advance_grid(input char_t c);
    int unsigned cols;
    int unsigned rows;
    int unsigned col;
    cnt_t        up_x;
    cnt_t        up_y;
    cnt_t        px;
    cnt_t        py;
    logic        last_col;
    logic        last_row;
    balance_t    r;
    cols = dim_limit(col_reg, MaxColumns);
    rows = dim_limit(row_reg, MaxRows);
    col  = (col_pos >= MaxColumns) ? MaxColumns - 1 : col_pos;
    if (c == CharX) begin
      row_x = row_x + 1'b1;
    end else if (c == CharY) begin
      row_y = row_y + 1'b1;
    end
    up_x = '0;
    up_y = '0;
    if (row_pos != 0) begin
      {up_y, up_x} = line_store[col];
    end
    px = up_x + row_x;
    py = up_y + row_y;
    line_store[col] = {py, px};
    if (col + 1 > stored_cols) stored_cols = col + 1;
    r.balanced = (px == py) && (px != '0);
    if (r.balanced) grid_total = grid_total + 1'b1;
    r.total  = grid_total;
    last_col = (col + 1 >= cols);
    last_row = (row_pos + 1 >= rows);
    r.done   = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_x   = '0;
      row_y   = '0;
      if (last_row) begin
        row_pos    = 0;
        grid_total = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos = col + 1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic send_cell(input char_t c, input logic typed, input balance_t want);
    while (!steady && $urandom_range(0, 99) < 35) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid     <= 1'b1;
    cell_if.cell_char <= c;
    cell_typed        <= typed;
    cell_want         <= want;
    do @(posedge clk_i); while (!cell_if.ready);
  endtask

  // Drain the pipeline, then write one register. A column count that would
  // reach line-store entries never written is cut back while below row 0.
  task automatic program_reg(input cfg_idx_t idx, input cfg_t value);
    cell_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_balances.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    if (idx == RegGridColumns && row_pos != 0 &&
        dim_limit(value, MaxColumns) > stored_cols) begin
      value = cfg_t'(stored_cols);
    end
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == RegGridColumns) begin
      col_reg = value;
    end else begin
      row_reg = value;
    end
    reg_writes++;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_if.ready <= steady || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk_i) begin : scoreboard
    balance_t want;
    logic     cell_beat;
    logic     result_beat;
    cell_beat   = rst_ni && cell_if.valid && cell_if.ready;
    result_beat = rst_ni && result_if.valid && result_if.ready;
    if (cell_beat) begin
      want = advance_grid(cell_if.cell_char);
      if (cell_typed) want = cell_want;
      awaited_balances.push_back(want);
      cells_sent++;
    end
    if (result_beat) begin
      results_seen++;
      if (result_if.grid_done) grids_seen++;
      if (result_if.cell_balanced) balanced_seen++;
      if (awaited_balances.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding");
      end else begin
        want = awaited_balances.pop_front();
        if (result_if.cell_balanced !== want.balanced) begin
          flag_mismatch($sformatf("cell_balanced %0b, expected %0b",
                                  result_if.cell_balanced, want.balanced));
        end
        if (result_if.balanced_total !== want.total) begin
          flag_mismatch($sformatf("balanced_total %0d, expected %0d",
                                  result_if.balanced_total, want.total));
        end
        if (result_if.grid_done !== want.done) begin
          flag_mismatch($sformatf("grid_done %0b, expected %0b",
                                  result_if.grid_done, want.done));
        end
      end
    end
    // Nothing moving on either channel for this long means the block hung.
    if (cell_beat || result_beat || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("grid_prefix_balance_counter verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          random_sent;
    int          n;
    int          left;
    int unsigned cols_eff;
    int unsigned rows_eff;
    int          pick;
    logic        both;
    cfg_t        new_cols;
    cfg_t        new_rows;
    char_t       c;
    cell_if.valid     = 1'b0;
    cell_if.cell_char = '0;
    cfg_we            = 1'b0;
    cfg_idx           = RegGridColumns;
    cfg_data          = '0;
    cell_typed        = 1'b0;
    cell_want         = NoCheck;
    steady            = 1'b0;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DrillPlan[i]) begin
      if (DrillPlan[i].kind == DrillReg) begin
        program_reg(DrillPlan[i].idx, DrillPlan[i].value);
      end else begin
        send_cell(DrillPlan[i].ch, DrillPlan[i].typed, DrillPlan[i].want);
      end
    end

    random_sent = 0;
    while (random_sent < RandomItems) begin
      if ($urandom_range(0, 99) < 80) begin
        pick = $urandom_range(0, 99);
        both = 1'b1;
        if (pick < 60) begin
          new_cols = cfg_t'($urandom_range(1, 6));
          new_rows = cfg_t'($urandom_range(1, 5));
        end else if (pick < 72) begin
          new_cols = cfg_t'($urandom_range(0, 1));
          new_rows = cfg_t'($urandom_range(0, 4));
        end else if (pick < 82) begin
          new_cols = cfg_t'($urandom_range(1, 4));
          new_rows = $urandom_range(0, 1) ? 11'd1024 : cfg_t'($urandom_range(1025, 2047));
        end else if (pick < 90) begin
          new_cols = $urandom_range(0, 1) ? 11'd1024 : cfg_t'($urandom_range(1025, 2047));
          new_rows = cfg_t'($urandom_range(1, 2));
        end else begin
          // Each register written or not at random, usually landing in the middle of a grid.
          both     = 1'b0;
          new_cols = cfg_t'($urandom_range(0, 7));
          new_rows = cfg_t'($urandom_range(0, 7));
        end
        if (both || $urandom_range(0, 1)) program_reg(RegGridColumns, new_cols);
        if (both || !$urandom_range(0, 1)) program_reg(RegGridRows, new_rows);
      end
      cols_eff = dim_limit(col_reg, MaxColumns);
      rows_eff = dim_limit(row_reg, MaxRows);
      left = (col_pos + 1 >= cols_eff) ? 1 : cols_eff - col_pos;
      if (row_pos + 1 < rows_eff) left += (rows_eff - row_pos - 1) * cols_eff;
      n = left;
      if (n > 48 || $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, (n > 48) ? 48 : n);
      end
      repeat (n) begin
        steady <= (random_sent >= 300 && random_sent < 550);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          c = CharX;
        end else if (pick < 80) begin
          c = CharY;
        end else begin
          c = char_t'($urandom_range(0, 255));
        end
        send_cell(c, 1'b0, NoCheck);
        random_sent++;
      end
    end

    cell_if.valid <= 1'b0;
    steady        <= 1'b0;
    @(posedge clk_i);
    while (awaited_balances.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d cells, %0d results checked, %0d grids completed, %0d balanced.",
             cells_sent, results_seen, grids_seen, balanced_seen);
    $display("Grid size registers written %0d times; %0d mismatches.",
             reg_writes, mismatches);
    if (mismatches == 0 && awaited_balances.size() == 0) begin
      $display("grid_prefix_balance_counter verification clean");
    end else begin
      $display("grid_prefix_balance_counter verification failed");
    end
    $finish;
  end

endmodule

@@ grid_prefix_balance_counter.f @@
+incdir+hdl
hdl/gpbc_pkg.sv
hdl/gpbc_in_if.sv
hdl/gpbc_out_if.sv
hdl/grid_prefix_balance_counter.sv
tb/tb.sv
